// ----- design/tsp_pkg.sv -----
// ============================================================================
// tsp_pkg: shared types and constants of the subtitle timestamp parser
// Holds the field widths, character codes, error codes, the parse phases and
// the finish record that the parser hands to the arithmetic stages.
// ============================================================================
package tsp_pkg;

    // Longest hours field that is accepted; one more digit is a range error.
    localparam int MAX_HOUR_DIGITS = 6;

    localparam int CHAR_W   = 16;
    localparam int HOURS_W  = $clog2(10 ** MAX_HOUR_DIGITS);
    localparam int DCNT_W   = 4;
    localparam int FIELD_W  = 7;
    localparam int MS_W     = 10;
    localparam int USED_W   = 6;
    localparam int MILLIS_W = 42;
    localparam int ERR_W    = 3;

    // Product widths: 3600000 < 2**22, 60000 < 2**16, 1000 < 2**10.
    localparam int HOUR_PROD_W = HOURS_W + 22;
    localparam int MIN_PROD_W  = FIELD_W + 16;
    localparam int SEC_PROD_W  = FIELD_W + 10;
    localparam int SUM_W = (HOUR_PROD_W + 1 > MILLIS_W + 1) ? HOUR_PROD_W + 1 : MILLIS_W + 1;

    localparam logic [21:0]        MS_PER_HOUR = 22'd3600000;
    localparam logic [15:0]        MS_PER_MIN  = 16'd60000;
    localparam logic [9:0]         MS_PER_SEC  = 10'd1000;
    localparam logic [FIELD_W-1:0] MAX_MINSEC  = 7'd59;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 3'd0,
        ERR_NO_DIGIT  = 3'd1,
        ERR_NO_COLON  = 3'd2,
        ERR_BAD_FIELD = 3'd3,
        ERR_NO_SEP    = 3'd4,
        ERR_BAD_MS    = 3'd5,
        ERR_RANGE     = 3'd6
    } t_err;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_FIRST  = 5'b00010,
        PH_SECOND = 5'b00100,
        PH_THIRD  = 5'b01000,
        PH_MILLI  = 5'b10000
    } t_phase;

    // Everything the arithmetic stages need about one finished timestamp.
    typedef struct packed {
        t_err                code;
        logic [USED_W-1:0]   used;
        logic [HOURS_W-1:0]  hours;
        logic [FIELD_W-1:0]  minutes;
        logic [FIELD_W-1:0]  seconds;
        logic [MS_W-1:0]     millis;
    } t_fin;

endpackage

// ----- design/tsp_ifs.sv -----
// ============================================================================
// tsp_ifs: stream interfaces of the subtitle timestamp parser
// One interface for the character stream and one for the parse results,
// each with a valid/ready handshake and its payload fields.
// ============================================================================
interface tsp_in_if;
    import tsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_end;

    modport source (output valid, output char_code, output is_end, input ready);
    modport sink   (input valid, input char_code, input is_end, output ready);
endinterface

interface tsp_out_if;
    import tsp_pkg::*;

    logic                valid;
    logic                ready;
    logic [MILLIS_W-1:0] millis;
    logic [ERR_W-1:0]    error_code;
    logic [USED_W-1:0]   chars_used;

    modport source (output valid, output millis, output error_code, output chars_used,
                    input ready);
    modport sink   (input valid, input millis, input error_code, input chars_used,
                    output ready);
endinterface

// ----- design/tsp_parse.sv -----
// ============================================================================
// tsp_parse: character-level parser
// Keeps the phase, digit count and field values, and registers a finish
// record on the item that ends the timestamp or shows an error.
// ============================================================================
module tsp_parse (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tsp_in_if.sink       i_in,
    output logic         o_fin_valid,
    input  logic         i_fin_ready,
    output tsp_pkg::t_fin o_fin
);
    import tsp_pkg::*;

    t_phase              r_phase, n_phase;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic [HOURS_W-1:0]  r_hours, n_hours;
    logic [FIELD_W-1:0]  r_minutes, n_minutes;
    logic [FIELD_W-1:0]  r_seconds, n_seconds;
    logic [MS_W-1:0]     r_millis, n_millis;
    logic                r_hmode, n_hmode;
    logic [USED_W-1:0]   r_used, n_used;

    logic                r_fin_valid;
    t_fin                r_fin;

    logic                accept;
    logic                is_num, is_colon, is_sep;
    logic [3:0]          digit;
    logic [USED_W-1:0]   used_inc;
    logic                fin_fire;
    t_err                fin_code;

    assign i_in.ready  = !r_fin_valid || i_fin_ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    assign is_num   = !i_in.is_end && (i_in.char_code >= CH_ZERO)
                      && (i_in.char_code <= CH_NINE);
    assign is_colon = !i_in.is_end && (i_in.char_code == CH_COLON);
    assign is_sep   = !i_in.is_end && ((i_in.char_code == CH_DOT)
                      || (i_in.char_code == CH_COMMA));
    // The low nibble of '0'..'9' is the digit value.
    assign digit    = i_in.char_code[3:0];
    assign used_inc = (r_used == '1) ? r_used : r_used + USED_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_dcnt    = r_dcnt;
        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        n_millis  = r_millis;
        n_hmode   = r_hmode;
        n_used    = r_used;
        fin_fire  = 1'b0;
        fin_code  = ERR_OK;

        case (r_phase)
            PH_IDLE: begin
                if (!is_num) begin
                    fin_fire = 1'b1;
                    fin_code = ERR_NO_DIGIT;
                end else begin
                    n_hours = HOURS_W'(digit);
                    n_dcnt  = DCNT_W'(1);
                    n_used  = USED_W'(1);
                    n_phase = PH_FIRST;
                end
            end
            PH_FIRST: begin
                if (is_num) begin
                    if (r_dcnt >= DCNT_W'(MAX_HOUR_DIGITS)) begin
                        fin_fire = 1'b1;
                        fin_code = ERR_RANGE;
                    end else begin
                        n_hours = r_hours * HOURS_W'(10) + HOURS_W'(digit);
                        n_dcnt  = r_dcnt + DCNT_W'(1);
                        n_used  = used_inc;
                    end
                end else if (!is_colon) begin
                    fin_fire = 1'b1;
                    fin_code = ERR_NO_COLON;
                end else begin
                    n_hmode = (r_dcnt != DCNT_W'(2)) || (r_hours > HOURS_W'(MAX_MINSEC));
                    n_dcnt  = '0;
                    n_used  = used_inc;
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (is_num) begin
                    if (r_dcnt >= DCNT_W'(2)) begin
                        fin_fire = 1'b1;
                        fin_code = ERR_BAD_FIELD;
                    end else begin
                        n_minutes = r_minutes * FIELD_W'(10) + FIELD_W'(digit);
                        n_dcnt    = r_dcnt + DCNT_W'(1);
                        n_used    = used_inc;
                    end
                end else if (r_dcnt != DCNT_W'(2)) begin
                    fin_fire = 1'b1;
                    fin_code = ERR_BAD_FIELD;
                end else if (is_colon) begin
                    n_hmode = 1'b1;
                    n_dcnt  = '0;
                    n_used  = used_inc;
                    n_phase = PH_THIRD;
                end else if (r_hmode) begin
                    fin_fire = 1'b1;
                    fin_code = ERR_NO_COLON;
                end else if (!is_sep) begin
                    fin_fire = 1'b1;
                    fin_code = ERR_NO_SEP;
                end else begin
                    // Only two fields: they were minutes and seconds.
                    n_seconds = r_minutes;
                    n_minutes = r_hours[FIELD_W-1:0];
                    n_hours   = '0;
                    n_dcnt    = '0;
                    n_used    = used_inc;
                    n_phase   = PH_MILLI;
                end
            end
            PH_THIRD: begin
                if (is_num) begin
                    if (r_dcnt >= DCNT_W'(2)) begin
                        fin_fire = 1'b1;
                        fin_code = ERR_BAD_FIELD;
                    end else begin
                        n_seconds = r_seconds * FIELD_W'(10) + FIELD_W'(digit);
                        n_dcnt    = r_dcnt + DCNT_W'(1);
                        n_used    = used_inc;
                    end
                end else if (r_dcnt != DCNT_W'(2)) begin
                    fin_fire = 1'b1;
                    fin_code = ERR_BAD_FIELD;
                end else if (!is_sep) begin
                    fin_fire = 1'b1;
                    fin_code = ERR_NO_SEP;
                end else begin
                    n_dcnt  = '0;
                    n_used  = used_inc;
                    n_phase = PH_MILLI;
                end
            end
            PH_MILLI: begin
                if (is_num) begin
                    if (r_dcnt >= DCNT_W'(3)) begin
                        fin_fire = 1'b1;
                        fin_code = ERR_BAD_MS;
                    end else begin
                        n_millis = r_millis * MS_W'(10) + MS_W'(digit);
                        n_dcnt   = r_dcnt + DCNT_W'(1);
                        n_used   = used_inc;
                    end
                end else if (r_dcnt != DCNT_W'(3)) begin
                    fin_fire = 1'b1;
                    fin_code = ERR_BAD_MS;
                end else begin
                    // Range and total checks happen in the arithmetic stages.
                    fin_fire = 1'b1;
                    fin_code = ERR_OK;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_dcnt  = '0;
                n_hours = '0;
                n_used  = '0;
            end
        endcase

        // Any finish returns the parser to idle with cleared state.
        if (fin_fire) begin
            n_phase   = PH_IDLE;
            n_dcnt    = '0;
            n_hours   = '0;
            n_minutes = '0;
            n_seconds = '0;
            n_millis  = '0;
            n_hmode   = 1'b0;
            n_used    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_dcnt    <= '0;
            r_hours   <= '0;
            r_minutes <= '0;
            r_seconds <= '0;
            r_millis  <= '0;
            r_hmode   <= 1'b0;
            r_used    <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_dcnt    <= n_dcnt;
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
            r_millis  <= n_millis;
            r_hmode   <= n_hmode;
            r_used    <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (accept && fin_fire) begin
            r_fin_valid <= 1'b1;
        end else if (i_fin_ready) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && fin_fire) begin
            r_fin.code    <= fin_code;
            r_fin.used    <= r_used;
            r_fin.hours   <= r_hours;
            r_fin.minutes <= r_minutes;
            r_fin.seconds <= r_seconds;
            r_fin.millis  <= r_millis;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_used == '0 && r_dcnt == '0 && r_hours == '0))
        else $error("parser idle with leftover state");

    a_no_digit_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && r_fin.code == ERR_NO_DIGIT) |-> (r_fin.used == '0))
        else $error("missing leading digit reported with characters used");

    a_field_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SECOND || r_phase == PH_THIRD) |-> (r_dcnt <= DCNT_W'(2)))
        else $error("two-digit field holds more than two digits");

    a_ok_fin_from_milli: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && fin_fire && fin_code == ERR_OK) |-> (r_phase == PH_MILLI))
        else $error("successful finish outside the milliseconds field");

endmodule

// ----- design/tsp_calc.sv -----
// ============================================================================
// tsp_calc: millisecond arithmetic and result register
// Stage one checks minutes and seconds and forms the three scaled products;
// stage two adds them, checks the 42-bit range and holds the result item.
// ============================================================================
module tsp_calc (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fin_valid,
    output logic          o_fin_ready,
    input  tsp_pkg::t_fin i_fin,
    tsp_out_if.source     o_out
);
    import tsp_pkg::*;

    logic                   r_a_valid;
    t_err                   r_a_code;
    logic [USED_W-1:0]      r_a_used;
    logic [HOUR_PROD_W-1:0] r_a_hp;
    logic [MIN_PROD_W-1:0]  r_a_mp;
    logic [SEC_PROD_W-1:0]  r_a_sp;
    logic [MS_W-1:0]        r_a_ms;

    logic                   r_o_valid;
    t_err                   r_o_code;
    logic [MILLIS_W-1:0]    r_o_millis;
    logic [USED_W-1:0]      r_o_used;

    logic                   ready_o, ready_a;
    logic                   range_bad;
    t_err                   n_a_code, n_o_code;
    logic [SUM_W-1:0]       total;
    logic                   total_ovf;

    assign ready_o     = !r_o_valid || o_out.ready;
    assign ready_a     = !r_a_valid || ready_o;
    assign o_fin_ready = ready_a;

    assign range_bad = (i_fin.minutes > MAX_MINSEC) || (i_fin.seconds > MAX_MINSEC);
    assign n_a_code  = (i_fin.code == ERR_OK && range_bad) ? ERR_RANGE : i_fin.code;

    assign total = SUM_W'(r_a_hp) + SUM_W'(r_a_mp) + SUM_W'(r_a_sp) + SUM_W'(r_a_ms);
    assign total_ovf = (total[SUM_W-1:MILLIS_W] != '0);
    assign n_o_code  = (r_a_code == ERR_OK && total_ovf) ? ERR_RANGE : r_a_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ready_a) begin
            r_a_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_fin_valid) begin
            r_a_code <= n_a_code;
            r_a_used <= i_fin.used;
            r_a_hp   <= HOUR_PROD_W'(i_fin.hours) * HOUR_PROD_W'(MS_PER_HOUR);
            r_a_mp   <= MIN_PROD_W'(i_fin.minutes) * MIN_PROD_W'(MS_PER_MIN);
            r_a_sp   <= SEC_PROD_W'(i_fin.seconds) * SEC_PROD_W'(MS_PER_SEC);
            r_a_ms   <= i_fin.millis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ready_o) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_o && r_a_valid) begin
            r_o_code   <= n_o_code;
            r_o_used   <= r_a_used;
            r_o_millis <= (n_o_code == ERR_OK) ? total[MILLIS_W-1:0] : '0;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.millis     = r_o_millis;
    assign o_out.error_code = ERR_W'(r_o_code);
    assign o_out.chars_used = r_o_used;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_code != ERR_OK) |-> (r_o_millis == '0))
        else $error("error result carries nonzero milliseconds");

    a_ok_minutes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_code == ERR_OK)
        |-> (r_a_mp <= MIN_PROD_W'(59 * 60000) && r_a_sp <= SEC_PROD_W'(59 * 1000)))
        else $error("minutes or seconds out of range passed as valid");

    a_stage_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && ready_o) |=> r_o_valid)
        else $error("stage one item lost on its way to the result register");

endmodule

// ----- design/subtitle_timestamp_parser_core.sv -----
// ============================================================================
// subtitle_timestamp_parser_core: streaming subtitle timestamp parser
// Parses H..:MM:SS.mmm or MM:SS.mmm from one character per item and emits the
// time in milliseconds, an error code and the count of characters used.
// ============================================================================
// Throughput: one character item per cycle unless stalled; the parser state
//   updates when it accepts an item, so consecutive items need no gap.
// Path: the result of the ending item goes through the finish register, the
//   product register and the result register, each of which can stall.
// Reset: i_rst_n is synchronous, active low; it returns the parser to idle
//   with all field values cleared and empties every pipeline stage.
module subtitle_timestamp_parser_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsp_in_if.sink    i_in,
    tsp_out_if.source o_out
);
    import tsp_pkg::*;

    // Finish record from the parser to the arithmetic stages. The parser only
    // stalls the character stream when its finish register is full and the
    // next stage cannot take it.
    logic fin_valid;
    logic fin_ready;
    t_fin fin;

    // The parser walks the fields digit by digit; hours, minutes, seconds and
    // milliseconds are accumulated with a multiply-by-ten per digit.
    tsp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_fin_valid (fin_valid),
        .i_fin_ready (fin_ready),
        .o_fin       (fin)
    );

    // The arithmetic scales each field to milliseconds in one stage and sums
    // them in the next, where the result also checks the 42-bit range.
    tsp_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .o_fin_ready (fin_ready),
        .i_fin       (fin),
        .o_out       (o_out)
    );

endmodule
